FILE: rtl/sed_pkg.sv
`timescale 1ns / 1ps

package sed_pkg;

  // Default depth of the queue between the front and the back
  localparam int unsigned QueueDepthDefault = 4;

  // Digit budgets of the numeric escapes
  localparam logic [2:0] DigitsOct     = 3'd3;  // \o and \0 (the 0 is not counted among them)
  localparam logic [2:0] DigitsDec     = 3'd3;  // \d
  localparam logic [2:0] DigitsHex     = 3'd2;  // \x
  localparam logic [2:0] DigitsOctLead = 3'd2;  // \1 .. \7, lead digit already taken

  // Characters and control codes
  localparam logic [7:0] ChrBackslash = 8'h5C;
  localparam logic [7:0] CodeBs       = 8'd8;
  localparam logic [7:0] CodeEsc      = 8'd27;
  localparam logic [7:0] CodeFf       = 8'd12;
  localparam logic [7:0] CodeLf       = 8'd10;
  localparam logic [7:0] CodeCr       = 8'd13;
  localparam logic [7:0] CodeTab      = 8'd9;

  typedef enum logic [2:0] {
    PH_PLAIN = 3'b001,
    PH_ESC   = 3'b010,
    PH_NUM   = 3'b100
  } phase_e;

  typedef enum logic [1:0] {
    RX_OCT = 2'd0,
    RX_DEC = 2'd1,
    RX_HEX = 2'd2
  } radix_e;

  // One result word
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       esc_error;
    logic       is_final;
  } result_t;

  // One queue entry: the one or two results caused by one input word
  typedef struct packed {
    result_t [1:0] res;
    logic          two;
  } entry_t;

  function automatic result_t mk_result(logic [7:0] data, logic has, logic err);
    result_t r;
    r.data      = has ? data : 8'd0;
    r.has_byte  = has;
    r.esc_error = err;
    r.is_final  = 1'b0;
    return r;
  endfunction

endpackage

FILE: rtl/sed_fifo.sv
`timescale 1ns / 1ps

module sed_fifo #(
  parameter int unsigned Depth = sed_pkg::QueueDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sed_pkg::entry_t entry_i,
  input  logic            pop_i,
  output sed_pkg::entry_t head_o,
  output logic            empty_o,
  output logic            full_o
);
  import sed_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(Depth));
  assign head_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

FILE: rtl/sed_front.sv
`timescale 1ns / 1ps

module sed_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      in_char_i,
  input  logic            is_end_i,
  input  logic            full_i,
  output logic            push_o,
  output sed_pkg::entry_t entry_o
);
  import sed_pkg::*;

  phase_e      phase_q, phase_d;
  radix_e      radix_q, radix_d;
  logic [2:0]  left_q, left_d;
  logic [9:0]  acc_q, acc_d;
  logic        got_q, got_d;

  logic        accept;
  logic        dig_ok, is_dig;
  logic [3:0]  dig_val;
  logic [12:0] acc_scaled;
  logic [9:0]  acc_next;
  logic [1:0]  n;
  logic        taken;
  result_t     res [2];

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Decode the character as a digit of the current radix
  always_comb begin
    dig_ok  = 1'b0;
    dig_val = 4'd0;
    if (in_char_i >= "0" && in_char_i <= "9") begin
      dig_ok  = 1'b1;
      dig_val = 4'(in_char_i - "0");
    end else if (in_char_i >= "a" && in_char_i <= "f") begin
      dig_ok  = 1'b1;
      dig_val = 4'(in_char_i - "a" + 8'd10);
    end else if (in_char_i >= "A" && in_char_i <= "F") begin
      dig_ok  = 1'b1;
      dig_val = 4'(in_char_i - "A" + 8'd10);
    end
    case (radix_q)
      RX_OCT:  is_dig = dig_ok && (dig_val < 4'd8);
      RX_DEC:  is_dig = dig_ok && (dig_val < 4'd10);
      default: is_dig = dig_ok;
    endcase
  end

  // Scale the running value by the radix: shifts and one add
  always_comb begin
    case (radix_q)
      RX_OCT:  acc_scaled = {acc_q, 3'b000};
      RX_DEC:  acc_scaled = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0};
      default: acc_scaled = {acc_q[8:0], 4'b0000};
    endcase
    acc_next = acc_scaled[9:0] + {6'd0, dig_val};
  end

  // Classify the word, step the escape state, collect up to two results
  always_comb begin
    phase_d = phase_q;
    radix_d = radix_q;
    left_d  = left_q;
    acc_d   = acc_q;
    got_d   = got_q;
    n       = 2'd0;
    taken   = 1'b0;
    res[0]  = '0;
    res[1]  = '0;

    if (phase_q == PH_NUM) begin
      if (is_dig) begin
        acc_d  = acc_next;
        got_d  = 1'b1;
        left_d = left_q - 3'd1;
        if (left_q == 3'd1) begin
          res[n[0]] = mk_result(acc_next[7:0], 1'b1, 1'b0);
          n         = n + 2'd1;
          phase_d   = PH_PLAIN;
          radix_d   = RX_OCT;
          left_d    = 3'd0;
          acc_d     = 10'd0;
          got_d     = 1'b0;
        end
        taken = 1'b1;
      end else begin
        if (got_q) begin
          res[n[0]] = mk_result(acc_q[7:0], 1'b1, 1'b0);
          n         = n + 2'd1;
        end
        phase_d = PH_PLAIN;
        radix_d = RX_OCT;
        left_d  = 3'd0;
        acc_d   = 10'd0;
        got_d   = 1'b0;
      end
    end

    if (!taken) begin
      if (phase_d == PH_ESC) begin
        phase_d = PH_PLAIN;
        case (in_char_i)
          "b": begin res[n[0]] = mk_result(CodeBs, 1'b1, 1'b0);  n = n + 2'd1; end
          "e": begin res[n[0]] = mk_result(CodeEsc, 1'b1, 1'b0); n = n + 2'd1; end
          "f": begin res[n[0]] = mk_result(CodeFf, 1'b1, 1'b0);  n = n + 2'd1; end
          "n": begin res[n[0]] = mk_result(CodeLf, 1'b1, 1'b0);  n = n + 2'd1; end
          "r": begin res[n[0]] = mk_result(CodeCr, 1'b1, 1'b0);  n = n + 2'd1; end
          "t": begin res[n[0]] = mk_result(CodeTab, 1'b1, 1'b0); n = n + 2'd1; end
          "o": begin
            phase_d = PH_NUM; radix_d = RX_OCT; left_d = DigitsOct;
            acc_d = 10'd0; got_d = 1'b0;
          end
          "d": begin
            phase_d = PH_NUM; radix_d = RX_DEC; left_d = DigitsDec;
            acc_d = 10'd0; got_d = 1'b0;
          end
          "x": begin
            phase_d = PH_NUM; radix_d = RX_HEX; left_d = DigitsHex;
            acc_d = 10'd0; got_d = 1'b0;
          end
          "0": begin
            phase_d = PH_NUM; radix_d = RX_OCT; left_d = DigitsOct;
            acc_d = 10'd0; got_d = 1'b1;
          end
          "8", "9": begin
            // drop: no byte
          end
          default: begin
            if (in_char_i >= "1" && in_char_i <= "7") begin
              phase_d = PH_NUM; radix_d = RX_OCT; left_d = DigitsOctLead;
              acc_d = {7'd0, in_char_i[2:0]}; got_d = 1'b1;
            end else begin
              res[n[0]] = mk_result(in_char_i, 1'b1, 1'b0);
              n         = n + 2'd1;
            end
          end
        endcase
      end else if (in_char_i == ChrBackslash) begin
        phase_d = PH_ESC;
      end else begin
        res[n[0]] = mk_result(in_char_i, 1'b1, 1'b0);
        n         = n + 2'd1;
      end
    end

    // Close the literal: flush an open number, flag a dangling backslash
    if (is_end_i) begin
      if (phase_d == PH_ESC) begin
        res[n[0]] = mk_result(8'd0, 1'b0, 1'b1);
        n         = n + 2'd1;
      end else begin
        if (phase_d == PH_NUM && got_d) begin
          res[n[0]] = mk_result(acc_d[7:0], 1'b1, 1'b0);
          n         = n + 2'd1;
        end
        if (n == 2'd0) begin
          res[0] = mk_result(8'd0, 1'b0, 1'b0);
          n      = 2'd1;
        end
      end
      if (n == 2'd2) begin
        res[1].is_final = 1'b1;
      end else begin
        res[0].is_final = 1'b1;
      end
      phase_d = PH_PLAIN;
      radix_d = RX_OCT;
      left_d  = 3'd0;
      acc_d   = 10'd0;
      got_d   = 1'b0;
    end
  end

  assign push_o        = accept && (n != 2'd0);
  assign entry_o.res[0] = res[0];
  assign entry_o.res[1] = res[1];
  assign entry_o.two    = (n == 2'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PLAIN;
      radix_q <= RX_OCT;
      left_q  <= 3'd0;
      acc_q   <= 10'd0;
      got_q   <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      radix_q <= radix_d;
      left_q  <= left_d;
      acc_q   <= acc_d;
      got_q   <= got_d;
    end
  end

endmodule

FILE: rtl/sed_back.sv
`timescale 1ns / 1ps

module sed_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  sed_pkg::entry_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            has_byte_o,
  output logic            esc_error_o,
  output logic            is_final_o
);
  import sed_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q, res_d;
  logic    idx_q, idx_d;
  logic    load;

  assign load = !valid_q || out_ready_i;

  // Hand out the results of the head entry one word at a time
  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    idx_d   = idx_q;
    pop_o   = 1'b0;
    if (load) begin
      if (!empty_i) begin
        valid_d = 1'b1;
        res_d   = head_i.res[idx_q];
        if (head_i.two && !idx_q) begin
          idx_d = 1'b1;
        end else begin
          idx_d = 1'b0;
          pop_o = 1'b1;
        end
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  // Hold the output word until taken
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = res_q.data;
  assign has_byte_o  = res_q.has_byte;
  assign esc_error_o = res_q.esc_error;
  assign is_final_o  = res_q.is_final;

endmodule

FILE: rtl/string_escape_decoder.sv
// A character's results pass through the entry queue and then the output register.
// Throughput: one character per clock while the queue is not full; results leave at one per
// clock while out_ready_i is high, so a character that yields two results (a closed number
// plus the next byte) gives the output side two words, absorbed by the entry queue between
// the decoder and the output register. Reset (asynchronous, active low) returns the escape
// state to plain text and empties the queue and the output register.
`timescale 1ns / 1ps

module string_escape_decoder #(
  parameter int unsigned QueueDepth = sed_pkg::QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_char_i,
  input  logic       is_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       has_byte_o,
  output logic       esc_error_o,
  output logic       is_final_o
);
  import sed_pkg::*;

  entry_t push_entry;
  entry_t head;
  logic   push, pop, empty, full;

  sed_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_char_i  (in_char_i),
    .is_end_i   (is_end_i),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  sed_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty),
    .full_o  (full)
  );

  sed_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .has_byte_o  (has_byte_o),
    .esc_error_o (esc_error_o),
    .is_final_o  (is_final_o)
  );

endmodule

FILE: dv/string_escape_decoder_checker.sv
`timescale 1ns / 1ps

module string_escape_decoder_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] in_char_i,
  input  logic       is_end_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] out_byte_i,
  input  logic       has_byte_i,
  input  logic       esc_error_i,
  input  logic       is_final_i,
  output int         fail_count_o,
  output int         pending_o
);
  import sed_pkg::*;

  // Decoder state as predicted from the accepted characters
  phase_e     phase_q;
  radix_e     radix_q;
  logic [2:0] left_q;
  logic [9:0] acc_q;
  logic       got_q;

  // Decoded results still waiting on the output channel
  result_t    decoded_q[$];
  int         step_n;
  int         mism_cnt;

  function automatic void clear_state();
    phase_q = PH_PLAIN;
    radix_q = RX_OCT;
    left_q  = 3'd0;
    acc_q   = 10'd0;
    got_q   = 1'b0;
  endfunction

  function automatic void start_number(radix_e rx, logic [2:0] left, logic [9:0] acc,
                                       logic got);
    phase_q = PH_NUM;
    radix_q = rx;
    left_q  = left;
    acc_q   = acc;
    got_q   = got;
  endfunction

  function automatic int radix_base();
    case (radix_q)
      RX_OCT:  return 8;
      RX_DEC:  return 10;
      default: return 16;
    endcase
  endfunction

  // Value of c as a digit of the open number, -1 if it is none
  function automatic int digit_value(logic [7:0] c);
    int v;
    v = -1;
    if (c >= "0" && c <= "9") v = int'(c) - int'("0");
    else if (c >= "a" && c <= "f") v = int'(c) - int'("a") + 10;
    else if (c >= "A" && c <= "F") v = int'(c) - int'("A") + 10;
    if (v >= radix_base()) v = -1;
    return v;
  endfunction

  function automatic void put_word(logic [7:0] b, logic has, logic err);
    result_t r;
    r.data      = has ? b : 8'd0;
    r.has_byte  = has;
    r.esc_error = err;
    r.is_final  = 1'b0;
    decoded_q.push_back(r);
    step_n++;
  endfunction

  // Work out the results that one accepted character causes
  function automatic void decode_char(logic [7:0] c, logic last);
    int      d;
    logic    taken;
    result_t r;
    taken  = 1'b0;
    step_n = 0;

    // Extend or close an open number
    if (phase_q == PH_NUM) begin
      d = digit_value(c);
      if (d >= 0) begin
        acc_q  = 10'(int'(acc_q) * radix_base() + d);
        got_q  = 1'b1;
        left_q = left_q - 3'd1;
        if (left_q == 3'd0) begin
          put_word(acc_q[7:0], 1'b1, 1'b0);
          clear_state();
        end
        taken = 1'b1;
      end else begin
        if (got_q) put_word(acc_q[7:0], 1'b1, 1'b0);
        clear_state();
      end
    end

    // Handle the character as escape letter or plain text
    if (!taken) begin
      if (phase_q == PH_ESC) begin
        phase_q = PH_PLAIN;
        case (c)
          "b": put_word(CodeBs, 1'b1, 1'b0);
          "e": put_word(CodeEsc, 1'b1, 1'b0);
          "f": put_word(CodeFf, 1'b1, 1'b0);
          "n": put_word(CodeLf, 1'b1, 1'b0);
          "r": put_word(CodeCr, 1'b1, 1'b0);
          "t": put_word(CodeTab, 1'b1, 1'b0);
          "o": start_number(RX_OCT, DigitsOct, 10'd0, 1'b0);
          "d": start_number(RX_DEC, DigitsDec, 10'd0, 1'b0);
          "x": start_number(RX_HEX, DigitsHex, 10'd0, 1'b0);
          "0": start_number(RX_OCT, DigitsOct, 10'd0, 1'b1);
          "8", "9": ;
          "1", "2", "3", "4", "5", "6", "7":
            start_number(RX_OCT, DigitsOctLead, 10'(c - "0"), 1'b1);
          default: put_word(c, 1'b1, 1'b0);
        endcase
      end else if (c == ChrBackslash) begin
        phase_q = PH_ESC;
      end else begin
        put_word(c, 1'b1, 1'b0);
      end
    end

    // Close the literal: flush a number, flag a dangling backslash, mark last
    if (last) begin
      if (phase_q == PH_ESC) begin
        put_word(8'd0, 1'b0, 1'b1);
      end else begin
        if (phase_q == PH_NUM && got_q) put_word(acc_q[7:0], 1'b1, 1'b0);
        if (step_n == 0) put_word(8'd0, 1'b0, 1'b0);
      end
      r = decoded_q.pop_back();
      r.is_final = 1'b1;
      decoded_q.push_back(r);
      clear_state();
    end
  endfunction

  // Predict on accepted characters, compare accepted results
  always @(posedge clk_i or negedge rst_ni) begin : watch_p
    result_t want;
    if (!rst_ni) begin
      clear_state();
      decoded_q.delete();
      mism_cnt = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (in_valid_i && in_ready_i) decode_char(in_char_i, is_end_i);
      if (out_valid_i && out_ready_i) begin
        if (decoded_q.size() == 0) begin
          mism_cnt++;
          if (mism_cnt <= 10)
            $display("%0t: unexpected word byte=%02h has=%0b err=%0b final=%0b", $realtime,
                     out_byte_i, has_byte_i, esc_error_i, is_final_i);
        end else begin
          want = decoded_q.pop_front();
          if (out_byte_i !== want.data || has_byte_i !== want.has_byte ||
              esc_error_i !== want.esc_error || is_final_i !== want.is_final) begin
            mism_cnt++;
            if (mism_cnt <= 10)
              $display("%0t: mismatch exp byte=%02h has=%0b err=%0b final=%0b, %s%02h %s%0b %s%0b %s%0b",
                       $realtime, want.data, want.has_byte, want.esc_error, want.is_final,
                       "got byte=", out_byte_i, "has=", has_byte_i, "err=", esc_error_i,
                       "final=", is_final_i);
          end
        end
      end
      fail_count_o <= mism_cnt;
      pending_o    <= decoded_q.size();
    end
  end

endmodule

FILE: dv/string_escape_decoder_test.sv
`timescale 1ns / 1ps

module string_escape_decoder_test;
  import sed_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int          ItemTarget = 950;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] in_char_i   = 8'h41;
  logic       is_end_i    = 1'b0;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       has_byte_o;
  logic       esc_error_o;
  logic       is_final_o;

  int          fail_count;
  int          pending;
  int unsigned cycle_cnt = 0;
  int          stall_left = 0;
  int          chars_sent = 0;
  logic [7:0]  lit_q[$];

  string_escape_decoder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_char_i   (in_char_i),
    .is_end_i    (is_end_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .has_byte_o  (has_byte_o),
    .esc_error_o (esc_error_o),
    .is_final_o  (is_final_o)
  );

  string_escape_decoder_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_char_i    (in_char_i),
    .is_end_i     (is_end_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_i   (out_byte_o),
    .has_byte_i   (has_byte_o),
    .esc_error_i  (esc_error_o),
    .is_final_i   (is_final_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Count cycles and stop a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Quiet windows with no idling on either side
  function automatic logic quiet_now();
    return ((cycle_cnt / 1500) % 3) == 2;
  endfunction

  // Idle length: mostly none or short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_now() || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // Stall the output side at random
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (!quiet_now() && $urandom_range(0, 99) < 25) begin
      out_ready_i <= 1'b0;
      stall_left  <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                  : $urandom_range(5, 24);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic send_word(input logic [7:0] c, input logic last);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_char_i  <= c;
    is_end_i   <= last;
    do @(posedge clk_i); while (!in_ready_o);
    chars_sent++;
  endtask

  task automatic send_literal();
    for (int i = 0; i < lit_q.size(); i++) send_word(lit_q[i], i == lit_q.size() - 1);
  endtask

  task automatic send_text(input string s);
    lit_q.delete();
    for (int i = 0; i < s.len(); i++) lit_q.push_back(s[i]);
    send_literal();
  endtask

  // Hold the sender until every predicted word has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_plain();
    logic [7:0] c;
    do begin
      c = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(32, 126))
                                      : 8'($urandom_range(1, 255));
    end while (c == ChrBackslash);
    return c;
  endfunction

  function automatic logic [7:0] pick_digit(radix_e rx);
    string hex_chars;
    hex_chars = "0123456789abcdefABCDEF";
    case (rx)
      RX_OCT:  return 8'("0" + $urandom_range(0, 7));
      RX_DEC:  return 8'("0" + $urandom_range(0, 9));
      default: return hex_chars[$urandom_range(0, 21)];
    endcase
  endfunction

  // Append a numeric escape with a random digit count, sometimes a breaker
  function automatic void add_number();
    string      leads, breakers;
    logic [7:0] lead;
    radix_e     rx;
    int         lim;
    leads    = "odx01234567";
    breakers = " +-gG9z\\\t";
    lead = leads[$urandom_range(0, 10)];
    case (lead)
      "o":     begin rx = RX_OCT; lim = 3; end
      "d":     begin rx = RX_DEC; lim = 3; end
      "x":     begin rx = RX_HEX; lim = 2; end
      "0":     begin rx = RX_OCT; lim = 3; end
      default: begin rx = RX_OCT; lim = 2; end
    endcase
    lit_q.push_back(ChrBackslash);
    lit_q.push_back(lead);
    repeat ($urandom_range(0, lim + 1)) lit_q.push_back(pick_digit(rx));
    if ($urandom_range(0, 99) < 40) lit_q.push_back(breakers[$urandom_range(0, 8)]);
  endfunction

  function automatic void add_token();
    string simple;
    int    r;
    simple = "befnrt";
    r = $urandom_range(0, 99);
    if (r < 30) begin
      lit_q.push_back(pick_plain());
    end else if (r < 45) begin
      lit_q.push_back(ChrBackslash);
      lit_q.push_back(simple[$urandom_range(0, 5)]);
    end else if (r < 75) begin
      add_number();
    end else if (r < 80) begin
      lit_q.push_back(ChrBackslash);
      lit_q.push_back(($urandom_range(0, 1) == 0) ? "8" : "9");
    end else if (r < 92) begin
      lit_q.push_back(ChrBackslash);
      lit_q.push_back(8'($urandom_range(1, 255)));
    end else begin
      lit_q.push_back(8'($urandom_range(1, 255)));
    end
  endfunction

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, dangling backslash, masking, empty and short numbers
    lit_q = '{8'h01, 8'hFF};
    send_literal();
    send_text("\\");
    send_text("\\0777");
    send_text("\\d999");
    send_text("\\x-");
    send_text("\\8");
    send_text("\\7");
    send_text("\\q");
    send_text("\\e");
    wait_drained();

    // Random literals, mostly well formed, draining after each literal near the middle
    while (chars_sent < ItemTarget) begin
      lit_q.delete();
      repeat ($urandom_range(1, 8)) add_token();
      if ($urandom_range(0, 99) < 8) lit_q.push_back(ChrBackslash);
      send_literal();
      if (chars_sent >= ItemTarget / 2 && chars_sent < ItemTarget / 2 + 40) wait_drained();
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

FILE: sim.f
rtl/sed_pkg.sv
rtl/sed_fifo.sv
rtl/sed_front.sv
rtl/sed_back.sv
rtl/string_escape_decoder.sv
dv/string_escape_decoder_checker.sv
dv/string_escape_decoder_test.sv
